// ===== src/mpsm_pkg.sv =====
// Shared types and constants for the multi-pattern string matcher.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package mpsm_pkg;

   // Automaton dimensions.
   localparam int STATES   = 256;
   localparam int ALPHABET = 256;
   localparam int PATTERNS = 16;

   // Field widths of a transaction.
   localparam int KIND_W  = 2;
   localparam int STATE_W = 8;
   localparam int SYM_W   = 8;
   localparam int PID_W   = 4;
   localparam int COUNT_W = 16;

   // Goto memory geometry and fail walk bound.
   localparam int GOTO_DEPTH = STATES * ALPHABET;
   localparam int GOTO_AW    = $clog2(GOTO_DEPTH);
   localparam int STEP_W     = $clog2(STATES + 1);

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Input transaction kinds.
   localparam logic [KIND_W-1:0] KIND_GOTO = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INFO = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TEXT = 2'd2;

   // Operations queued for the back end.
   localparam logic [1:0] OP_GOTO = 2'd0;
   localparam logic [1:0] OP_INFO = 2'd1;
   localparam logic [1:0] OP_SCAN = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [STATE_W-1:0] state_index;
      logic [SYM_W-1:0]   symbol;
      logic [STATE_W-1:0] target_state;
      logic [STATE_W-1:0] fail_state;
      logic               has_pattern;
      logic [PID_W-1:0]   pattern_id;
   } req_type;

   typedef struct packed {
      logic [STATE_W-1:0] current_state;
      logic               matched;
      logic [PID_W-1:0]   match_pattern;
      logic [COUNT_W-1:0] match_count;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [PID_W-1:0] id;
   } mark_type;

   typedef struct packed {
      logic [STATE_W-1:0] fail;
      mark_type           mark;
   } info_type;

   // A classified operation as it waits in the queue.
   typedef struct packed {
      logic [1:0]         op;
      logic [STATE_W-1:0] state_index;
      logic [SYM_W-1:0]   symbol;
      logic [STATE_W-1:0] target_state;
      info_type           info;
   } work_type;

endpackage

`default_nettype wire

// ===== src/multi_pattern_string_matcher.sv =====
// Top level of the multi-pattern string matcher: front end, operation queue and back end.
// Depends on mpsm_pkg, mpsm_front, mpsm_queue and mpsm_back.
`timescale 1ns / 1ps
`default_nettype none

// Aho-Corasick matcher over a byte stream. Table writes (goto transitions, fail links
// and pattern marks) and text bytes all arrive on the req_ channel; each text byte gives
// one rsp_ transaction with the new state and, if that state ends a pattern, the pattern
// number and its saturating match count. After reset the block clears its 65536-entry
// goto memory one entry per cycle and holds req_stall high until the pass is done.
// A table write is applied as it is popped, leaving the back end idle. A text byte goes
// through the lookup and evaluate states, again for each fail link followed, then the
// mark and result states; the goto and info memories are read once per step with
// registered read data. A walk is bounded at 256 fail steps plus one retry from the
// root. The front stage and two-entry queue accept new transactions during a walk.
module multi_pattern_string_matcher (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mpsm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mpsm_pkg::rsp_type rsp_data
);
   import mpsm_pkg::*;

   logic     clear_busy;
   logic     queue_full;
   logic     push_valid;
   work_type push_data;
   logic     work_pop;
   logic     work_valid;
   work_type work_data;

   mpsm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .clear_busy (clear_busy),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   mpsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (work_pop),
      .pop_valid  (work_valid),
      .pop_data   (work_data)
   );

   mpsm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid),
      .work_data  (work_data),
      .work_pop   (work_pop),
      .clear_busy (clear_busy),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== src/mpsm_front.sv =====
// Front end: accepts input transactions, checks and classifies them into queue operations.
// Depends on mpsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpsm_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mpsm_pkg::req_type  req_data,
   input  logic               clear_busy,
   input  logic               queue_full,
   output logic               push_valid,
   output mpsm_pkg::work_type push_data
);
   import mpsm_pkg::*;

   function automatic logic in_states(input logic [STATE_W-1:0] v);
      in_states = int'(v) < STATES;
   endfunction

   function automatic logic in_alphabet(input logic [SYM_W-1:0] v);
      in_alphabet = int'(v) < ALPHABET;
   endfunction

   function automatic logic in_patterns(input logic [PID_W-1:0] v);
      in_patterns = int'(v) < PATTERNS;
   endfunction

   logic     stage_valid_ff, stage_valid_in;
   work_type stage_ff, stage_in;
   work_type classified;
   logic     keep;
   logic     take;
   logic     drained;

   // Classify the transaction; writes outside the tables and unknown kinds are dropped.
   always_comb begin
      classified              = '0;
      classified.state_index  = req_data.state_index;
      classified.symbol       = req_data.symbol;
      classified.target_state = req_data.target_state;
      keep                    = 1'b0;
      unique case (req_data.kind)
         KIND_GOTO: begin
            classified.op = OP_GOTO;
            keep = in_states(req_data.state_index) && in_alphabet(req_data.symbol) &&
                   in_states(req_data.target_state);
         end
         KIND_INFO: begin
            classified.op        = OP_INFO;
            keep                 = in_states(req_data.state_index);
            classified.info.fail = in_states(req_data.fail_state) ? req_data.fail_state : '0;
            classified.info.mark.valid = req_data.has_pattern && in_patterns(req_data.pattern_id);
            classified.info.mark.id    = classified.info.mark.valid ? req_data.pattern_id : '0;
         end
         KIND_TEXT: begin
            classified.op = OP_SCAN;
            keep          = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // One staging register in front of the queue.
   assign req_stall  = clear_busy || (stage_valid_ff && queue_full);
   assign take       = req_valid && !req_stall;
   assign drained    = stage_valid_ff && !queue_full;
   assign push_valid = stage_valid_ff;
   assign push_data  = stage_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_in       = stage_ff;
      if (take && keep) begin
         stage_valid_in = 1'b1;
         stage_in       = classified;
      end else if (drained) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

`default_nettype wire

// ===== src/mpsm_queue.sv =====
// Two-entry queue of classified operations between the front and back ends.
// Depends on mpsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpsm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  mpsm_pkg::work_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output mpsm_pkg::work_type pop_data
);
   import mpsm_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/mpsm_back.sv =====
// Back end: holds the goto and state-info memories, walks the automaton for each text
// byte, keeps the per-pattern match counters and drives the result register. Depends on mpsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpsm_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               work_valid,
   input  mpsm_pkg::work_type work_data,
   output logic               work_pop,
   output logic               clear_busy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mpsm_pkg::rsp_type  rsp_data
);
   import mpsm_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOOKUP = 3'd1;
   localparam logic [2:0] ST_EVAL   = 3'd2;
   localparam logic [2:0] ST_MARK   = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   function automatic logic [GOTO_AW-1:0] goto_addr(input logic [STATE_W-1:0] s,
                                                    input logic [SYM_W-1:0] c);
      goto_addr = GOTO_AW'(s) * GOTO_AW'(ALPHABET) + GOTO_AW'(c);
   endfunction

   // Memories and their registered read data.
   logic [STATE_W-1:0] goto_mem [GOTO_DEPTH];
   info_type           info_mem [STATES];
   logic [STATE_W-1:0] goto_rd_ff;
   info_type           info_rd_ff;

   logic               goto_we;
   logic [GOTO_AW-1:0] goto_wa;
   logic [STATE_W-1:0] goto_wd;
   logic [GOTO_AW-1:0] goto_ra;
   logic               info_we;
   logic [STATE_W-1:0] info_wa;
   info_type           info_wd;
   logic [STATE_W-1:0] info_ra;

   // Control and walk registers.
   logic [2:0]         state_ff, state_in;
   logic [STATE_W-1:0] scan_ff, scan_in;
   logic [STATE_W-1:0] walk_ff, walk_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic               clr_busy_ff, clr_busy_in;
   logic [GOTO_AW-1:0] clr_addr_ff, clr_addr_in;
   logic [COUNT_W-1:0] cnt_ff [PATTERNS];
   logic [COUNT_W-1:0] cnt_in [PATTERNS];
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               out_free;
   logic               result_load;
   logic               hit;
   logic [COUNT_W-1:0] cnt_cur;
   logic [COUNT_W-1:0] cnt_next;

   assign clear_busy = clr_busy_ff;
   assign work_pop   = (state_ff == ST_IDLE) && !clr_busy_ff && work_valid;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Clearing pass over the goto memory after reset; the info memory is cleared alongside.
   assign clr_addr_in = clr_busy_ff ? clr_addr_ff + GOTO_AW'(1) : clr_addr_ff;
   assign clr_busy_in = clr_busy_ff && (clr_addr_ff != GOTO_AW'(GOTO_DEPTH - 1));

   // Write port selection: clearing pass or a queued table write.
   always_comb begin
      goto_we = 1'b0;
      goto_wa = goto_addr(work_data.state_index, work_data.symbol);
      goto_wd = work_data.target_state;
      info_we = 1'b0;
      info_wa = work_data.state_index;
      info_wd = work_data.info;
      if (clr_busy_ff) begin
         goto_we = 1'b1;
         goto_wa = clr_addr_ff;
         goto_wd = '0;
         info_we = 1'b1;
         info_wa = clr_addr_ff[STATE_W-1:0];
         info_wd = '0;
      end else if (work_pop) begin
         goto_we = work_data.op == OP_GOTO;
         info_we = work_data.op == OP_INFO;
      end
   end

   assign goto_ra = goto_addr(walk_ff, sym_ff);
   assign info_ra = walk_ff;

   always_ff @(posedge clock) begin
      if (goto_we) begin
         goto_mem[goto_wa] <= goto_wd;
      end
      goto_rd_ff <= goto_mem[goto_ra];
   end

   always_ff @(posedge clock) begin
      if (info_we) begin
         info_mem[info_wa] <= info_wd;
      end
      info_rd_ff <= info_mem[info_ra];
   end

   // Match evaluation on the final state's mark.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign hit      = info_rd_ff.mark.valid && (int'(info_rd_ff.mark.id) < PATTERNS);
   assign cnt_cur  = cnt_ff[info_rd_ff.mark.id];
   assign cnt_next = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_W'(1);
   assign result_load = (state_ff == ST_RESULT) && out_free;

   always_comb begin
      rsp_data_in               = rsp_data_ff;
      rsp_valid_in              = rsp_valid_ff && rsp_stall;
      if (result_load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.current_state = walk_ff;
         rsp_data_in.matched       = hit;
         rsp_data_in.match_pattern = hit ? info_rd_ff.mark.id : '0;
         rsp_data_in.match_count   = hit ? cnt_next : '0;
      end
   end

   always_comb begin
      for (int i = 0; i < PATTERNS; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      if (result_load && hit) begin
         cnt_in[info_rd_ff.mark.id] = cnt_next;
      end
   end

   // Walk sequencer: one goto and fail lookup per step until a transition or the root ends it.
   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      walk_in  = walk_ff;
      sym_in   = sym_ff;
      steps_in = steps_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (work_pop && (work_data.op == OP_SCAN)) begin
               walk_in  = scan_ff;
               sym_in   = work_data.symbol;
               steps_in = '0;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (goto_rd_ff != '0) begin
               walk_in  = goto_rd_ff;
               state_in = ST_MARK;
            end else if (walk_ff == '0) begin
               state_in = ST_MARK;
            end else if (steps_ff == STEP_W'(STATES)) begin
               // Fail links form a cycle: retry the byte from the root.
               walk_in  = '0;
               state_in = ST_LOOKUP;
            end else begin
               walk_in  = info_rd_ff.fail;
               steps_in = steps_ff + STEP_W'(1);
               state_in = ST_LOOKUP;
            end
         end
         ST_MARK: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               scan_in  = walk_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PATTERNS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < PATTERNS; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      walk_ff     <= walk_in;
      sym_ff      <= sym_in;
      steps_ff    <= steps_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== src/mpsm_checker.sv =====
// Port-level checks for the multi-pattern string matcher, bound to its top level.
// Depends on mpsm_pkg and multi_pattern_string_matcher.
`timescale 1ns / 1ps
`default_nettype none

module mpsm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mpsm_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mpsm_pkg::rsp_type rsp_data
);
   import mpsm_pkg::*;

   // A stalled result transaction stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result transaction changed while stalled");

   // Without a match the pattern and count fields are zero.
   a_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.matched |->
         rsp_data.match_pattern == '0 && rsp_data.match_count == '0)
      else $error("pattern fields set on a result without a match");

   // A reported match has counted at least itself.
   a_match_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.matched |-> rsp_data.match_count != '0)
      else $error("match reported with a zero count");

   // Right after reset the clearing pass holds off input and no result is shown.
   a_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall && !rsp_valid)
      else $error("block not in its clearing pass after reset");

endmodule

bind multi_pattern_string_matcher mpsm_checker u_checker (.*);

`default_nettype wire

// ===== test/tb_multi_pattern_string_matcher.sv =====
// Self-checking testbench for the multi-pattern string matcher (Aho-Corasick scanner).
// Depends on mpsm_pkg for the transaction types and on the multi_pattern_string_matcher RTL.
// A scoreboard tracks the automaton tables and predicts each text-byte result.
`timescale 1ns / 1ps

module tb_multi_pattern_string_matcher;
   import mpsm_pkg::*;

   // Kind code that the block drops without a result.
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   localparam int CYCLE_LIMIT      = 8_000_000;
   localparam int DRAIN_CYCLES     = 1200;
   localparam int RANDOM_ITEMS     = 1800;
   localparam int LOOP_BYTES       = 60;
   localparam int REPORT_CAP       = 30;

   // Tracks the automaton tables and the scan state, and holds the outstanding results.
   class matcher_scoreboard;
      bit [STATE_W-1:0] goto_mem [GOTO_DEPTH];
      bit [STATE_W-1:0] fail_link [STATES];
      bit               mark_valid [STATES];
      bit [PID_W-1:0]   mark_id [STATES];
      bit [COUNT_W-1:0] hit_count [PATTERNS];
      bit [STATE_W-1:0] scan_state;
      rsp_type          awaited_matches [$];
      int errors, n_writes, n_text, n_matches, n_bounded, n_saturated, n_checked;

      // Applies one accepted transaction; a text byte also queues its predicted result.
      function void absorb_request(req_type r);
         int unsigned      s;
         int unsigned      steps;
         bit               done;
         bit [STATE_W-1:0] t;
         rsp_type          e;
         case (r.kind)
            KIND_GOTO: begin
               goto_mem[r.state_index * ALPHABET + r.symbol] = r.target_state;
               n_writes++;
            end
            KIND_INFO: begin
               fail_link[r.state_index]  = r.fail_state;
               mark_valid[r.state_index] = r.has_pattern;
               mark_id[r.state_index]    = r.pattern_id;
               n_writes++;
            end
            KIND_TEXT: begin
               // Follow fail links until a transition exists; give up to the root
               // after a full table of steps so that cyclic links still end.
               s     = scan_state;
               steps = 0;
               done  = 1'b0;
               while (!done) begin
                  t = goto_mem[s * ALPHABET + r.symbol];
                  if (t != 0) begin
                     s    = t;
                     done = 1'b1;
                  end else if (s == 0) begin
                     done = 1'b1;
                  end else if (steps >= STATES) begin
                     s    = goto_mem[r.symbol];
                     done = 1'b1;
                     n_bounded++;
                  end else begin
                     s = fail_link[s];
                     steps++;
                  end
               end
               scan_state      = STATE_W'(s);
               e               = '0;
               e.current_state = STATE_W'(s);
               if (mark_valid[s]) begin
                  if (hit_count[mark_id[s]] != COUNT_MAX) begin
                     hit_count[mark_id[s]]++;
                  end
                  e.matched       = 1'b1;
                  e.match_pattern = mark_id[s];
                  e.match_count   = hit_count[mark_id[s]];
                  n_matches++;
                  if (e.match_count == COUNT_MAX) begin
                     n_saturated++;
                  end
               end
               awaited_matches = {awaited_matches, e};
               n_text++;
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= REPORT_CAP) begin
            $display("ERROR: %s", what);
         end
      endtask

      // Compares one result transaction with the oldest prediction.
      task check_result(rsp_type got);
         rsp_type want;
         n_checked++;
         if (awaited_matches.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding", n_checked));
         end else begin
            want = awaited_matches.pop_front();
            if (got.current_state !== want.current_state) begin
               report_mismatch($sformatf("result %0d: current_state %0d, predicted %0d",
                                         n_checked, got.current_state, want.current_state));
            end
            if (got.matched !== want.matched) begin
               report_mismatch($sformatf("result %0d: matched %0b, predicted %0b",
                                         n_checked, got.matched, want.matched));
            end
            if (got.match_pattern !== want.match_pattern) begin
               report_mismatch($sformatf("result %0d: match_pattern %0d, predicted %0d",
                                         n_checked, got.match_pattern, want.match_pattern));
            end
            if (got.match_count !== want.match_count) begin
               report_mismatch($sformatf("result %0d: match_count %0d, predicted %0d",
                                         n_checked, got.match_count, want.match_count));
            end
         end
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int cycle_count   = 0;
   matcher_scoreboard sb;

   multi_pattern_string_matcher u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Guard against a hang.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Result monitor: every accepted transaction goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_data);
      end
   end

   // Receiver back-pressure in random bursts.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Fully random transaction of the ignored kind; the builders below overwrite fields.
   function automatic req_type random_req();
      req_type r;
      r.kind         = KIND_NONE;
      r.state_index  = STATE_W'($urandom);
      r.symbol       = SYM_W'($urandom);
      r.target_state = STATE_W'($urandom);
      r.fail_state   = STATE_W'($urandom);
      r.has_pattern  = 1'($urandom);
      r.pattern_id   = PID_W'($urandom);
      return r;
   endfunction

   function automatic req_type goto_req(input logic [STATE_W-1:0] s,
                                        input logic [SYM_W-1:0] c,
                                        input logic [STATE_W-1:0] t);
      req_type r;
      r              = random_req();
      r.kind         = KIND_GOTO;
      r.state_index  = s;
      r.symbol       = c;
      r.target_state = t;
      return r;
   endfunction

   function automatic req_type info_req(input logic [STATE_W-1:0] s,
                                        input logic [STATE_W-1:0] f,
                                        input logic h,
                                        input logic [PID_W-1:0] p);
      req_type r;
      r             = random_req();
      r.kind        = KIND_INFO;
      r.state_index = s;
      r.fail_state  = f;
      r.has_pattern = h;
      r.pattern_id  = p;
      return r;
   endfunction

   function automatic req_type text_req(input logic [SYM_W-1:0] c);
      req_type r;
      r        = random_req();
      r.kind   = KIND_TEXT;
      r.symbol = c;
      return r;
   endfunction

   // Presents one transaction, waits for acceptance, then maybe idles for a burst.
   task automatic send_item(input req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.absorb_request(item);
      if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   initial begin
      bit [STATE_W-1:0] ids [16];
      bit [SYM_W-1:0]   syms [4];
      bit [STATES-1:0]  taken;
      bit [SYM_W-1:0]   sat_sym;
      bit [STATE_W-1:0] sat_state;
      bit               col_free;
      bit               found;
      req_type          noise;
      int               n_states, n_syms, n_bytes, roll, sym_base, c, s, i, j;

      sb        = new();
      req_valid = 1'b0;
      req_data  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with moderate idling on both sides.
      req_gap_pct   = 30;
      rsp_stall_pct = 30;
      // Scans over empty tables and an ignored kind.
      send_item(text_req(8'h00));
      send_item(text_req(8'hFF));
      send_item(random_req());
      // A two-state pattern, plus a root transition on the top byte value.
      send_item(goto_req(8'd0, 8'h41, 8'd1));
      send_item(goto_req(8'd1, 8'h42, 8'd2));
      send_item(info_req(8'd2, 8'd0, 1'b1, 4'd15));
      send_item(info_req(8'd1, 8'd0, 1'b0, 4'd7));
      send_item(goto_req(8'd0, 8'hFF, 8'hFF));
      send_item(info_req(8'hFF, 8'd0, 1'b1, 4'd0));
      send_item(text_req(8'h41));
      send_item(text_req(8'h42));
      send_item(text_req(8'hFF));
      send_item(text_req(8'h00));
      // A final state in the middle of a branch, reached twice in a row.
      send_item(info_req(8'd1, 8'd0, 1'b1, 4'd3));
      send_item(text_req(8'h41));
      send_item(text_req(8'h41));
      // Two states whose fail links point at each other: the walk hits its bound,
      // once with no root transition and once with one.
      send_item(goto_req(8'd0, 8'h43, 8'd3));
      send_item(info_req(8'd3, 8'd4, 1'b0, 4'd0));
      send_item(info_req(8'd4, 8'd3, 1'b0, 4'd0));
      send_item(text_req(8'h43));
      send_item(text_req(8'h5A));
      send_item(text_req(8'h43));
      send_item(text_req(8'h41));
      // A zero target removes a transition.
      send_item(goto_req(8'd0, 8'h41, 8'd0));
      send_item(text_req(8'h41));
      send_item(info_req(8'd5, 8'hFF, 1'b0, 4'd0));
      send_item(info_req(8'd4, 8'd0, 1'b0, 4'd0));

      // Random part: each round loads a small automaton over a few byte values
      // and then scans text drawn mostly from those bytes.
      while (sb.n_writes + sb.n_text < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0: req_gap_pct = 0;
            1: req_gap_pct = 10;
            default: req_gap_pct = 40;
         endcase
         case ($urandom_range(0, 2))
            0: rsp_stall_pct = 0;
            1: rsp_stall_pct = 10;
            default: rsp_stall_pct = 40;
         endcase
         n_states = $urandom_range(3, 16);
         n_syms   = $urandom_range(2, 4);
         taken    = '0;
         taken[0] = 1'b1;
         ids[0]   = '0;
         for (i = 1; i < n_states; i++) begin
            do s = $urandom_range(1, STATES - 1); while (taken[s]);
            taken[s] = 1'b1;
            ids[i]   = STATE_W'(s);
         end
         for (j = 0; j < n_syms; j++) begin
            syms[j] = SYM_W'($urandom);
         end
         // Occasionally mark the root itself.
         if ($urandom_range(0, 9) == 0) begin
            send_item(info_req('0, STATE_W'($urandom), 1'($urandom_range(0, 3) == 0),
                               PID_W'($urandom)));
         end
         // Fail links point to states listed earlier, so every chain ends at the root.
         for (i = 1; i < n_states; i++) begin
            send_item(info_req(ids[i], ids[$urandom_range(0, i - 1)], 1'($urandom),
                               PID_W'($urandom)));
         end
         for (i = 0; i < n_states; i++) begin
            for (j = 0; j < n_syms; j++) begin
               roll = $urandom_range(0, 9);
               if (roll < 6) begin
                  send_item(goto_req(ids[i], syms[j], ids[$urandom_range(1, n_states - 1)]));
               end else if (roll == 6) begin
                  send_item(goto_req(ids[i], syms[j], '0));
               end
            end
         end
         n_bytes = $urandom_range(30, 80);
         repeat (n_bytes) begin
            roll = $urandom_range(0, 99);
            if (roll < 90) begin
               send_item(text_req(syms[$urandom_range(0, n_syms - 1)]));
            end else if (roll < 97) begin
               send_item(text_req(SYM_W'($urandom)));
            end else if (roll < 99) begin
               send_item(random_req());
            end else begin
               noise      = random_req();
               noise.kind = KIND_GOTO;
               send_item(noise);
            end
         end
      end

      // Final part without idling: a back-to-back run of bytes on a marked state that
      // loops on itself. Pick a byte with no transition anywhere, so every walk lands
      // on the loop state.
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      sym_base      = $urandom_range(0, ALPHABET - 1);
      sat_sym       = SYM_W'(sym_base);
      found         = 1'b0;
      for (c = 0; c < ALPHABET && !found; c++) begin
         col_free = 1'b1;
         for (s = 0; s < STATES; s++) begin
            if (sb.goto_mem[s * ALPHABET + (sym_base + c) % ALPHABET] != 0) begin
               col_free = 1'b0;
            end
         end
         if (col_free) begin
            found   = 1'b1;
            sat_sym = SYM_W'((sym_base + c) % ALPHABET);
         end
      end
      sat_state = STATE_W'($urandom_range(1, STATES - 1));
      send_item(goto_req('0, sat_sym, sat_state));
      send_item(goto_req(sat_state, sat_sym, sat_state));
      send_item(info_req(sat_state, '0, 1'b1, PID_W'($urandom)));
      repeat (LOOP_BYTES) send_item(text_req(sat_sym));
      req_valid <= 1'b0;

      // Drain, then allow time for any stray result.
      while (sb.awaited_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d table writes and %0d text bytes; %0d pattern hits, %0d at the ceiling.",
               sb.n_writes, sb.n_text, sb.n_matches, sb.n_saturated);
      $display("Summary: %0d scans ran into the fail-walk bound; %0d results checked.",
               sb.n_bounded, sb.n_checked);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
